// ----- hw/rtl/htw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_pkg: shared types and constants of the Huffman tree-walk decoder
// Item layouts, node layout, the front-to-back command and the register map.
// ----------------------------------------------------------------------------
package htw_pkg;

    localparam int NODE_COUNT_DEF = 512;
    localparam int BYTE           = 8;
    localparam int IDX_W          = 9;
    localparam int SYM_W          = 8;
    localparam int LEN_W          = 31;
    localparam int BIT_W          = $clog2(BYTE);

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_ROOT_NODE      = 1'b0;
    localparam logic REG_MESSAGE_LENGTH = 1'b1;

    // Request kinds.
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [IDX_W-1:0] node_index;
        logic [IDX_W-1:0] left_child;
        logic [IDX_W-1:0] right_child;
        logic             is_leaf;
        logic [SYM_W-1:0] leaf_symbol;
        logic [BYTE-1:0]  data_byte;
    } req_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last_in_run;
        logic             message_done;
    } rsp_t;

    typedef struct packed {
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic             leaf;
        logic [SYM_W-1:0] sym;
    } node_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] index;
        node_t            node;
        logic [BYTE-1:0]  data;
    } cmd_t;

    // Register values and write events seen by the back.
    typedef struct packed {
        logic [IDX_W-1:0] root;
        logic [LEN_W-1:0] msg_len;
        logic             root_wr;
        logic [IDX_W-1:0] root_wdata;
        logic             len_wr;
    } cfg_t;

endpackage

// ----- hw/rtl/htw_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_front: item intake and command queue
// Accepts items, sorts them into load and decode commands and queues them.
// ----------------------------------------------------------------------------
module htw_front
    import htw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output cmd_t cmd,
    output logic cmd_valid,
    input  logic cmd_pop
);

    cmd_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    cmd_t              cmd_in;

    assign busy      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push      = start && !busy;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];

    // A load carries only the index and node; a decode carries only the byte.
    always_comb
    begin
        cmd_in = '0;
        cmd_in.kind = request.req_type;
        if (request.req_type == REQ_LOAD)
        begin
            cmd_in.index      = request.node_index;
            cmd_in.node.left  = request.left_child;
            cmd_in.node.right = request.right_child;
            cmd_in.node.leaf  = request.is_leaf;
            cmd_in.node.sym   = request.leaf_symbol;
        end
        else
        begin
            cmd_in.data = request.data_byte;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_W'(1);
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !cmd_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ----- hw/rtl/htw_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_back: node store and tree walker
// Writes nodes, walks the tree one bit per child-node read, emits symbols.
// ----------------------------------------------------------------------------
module htw_back
    import htw_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  logic cmd_valid,
    output logic cmd_pop,
    input  cfg_t cfg,
    output logic result_valid,
    output rsp_t result
);

    localparam int AW = $clog2(NODE_COUNT);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CUR   = 4'b0010,
        ST_CHILD = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    node_t            mem [NODE_COUNT];
    node_t            rd_q;
    logic             oor_q;
    node_t            rd_node;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] cur_idx_reg;
    logic [IDX_W-1:0] cur_idx_next;
    node_t            cur_reg;
    node_t            cur_next;
    logic             cur_valid_reg;
    logic             cur_valid_next;
    logic [IDX_W-1:0] nxt_idx_reg;
    logic [IDX_W-1:0] nxt_idx_next;
    logic [BYTE-1:0]  byte_reg;
    logic [BYTE-1:0]  byte_next;
    logic [BIT_W-1:0] bit_reg;
    logic [BIT_W-1:0] bit_next;
    logic [LEN_W-1:0] cnt_reg;
    logic [LEN_W-1:0] cnt_next;
    logic [LEN_W-1:0] cnt_inc;
    logic             pend_valid_reg;
    logic             pend_valid_next;
    rsp_t             pend_reg;
    rsp_t             pend_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    rsp_t             out_reg;
    rsp_t             out_next;

    logic             mem_we;
    logic [IDX_W-1:0] raddr;
    logic             byte_end;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign cmd_pop      = (state_reg == ST_IDLE) && cmd_valid;
    assign mem_we       = cmd_pop && (cmd.kind == REQ_LOAD)
                       && (32'(cmd.index) < NODE_COUNT);
    assign rd_node      = oor_q ? '0 : rd_q;
    assign cnt_inc      = cnt_reg + LEN_W'(1);
    assign byte_end     = (bit_reg == '0);

    // Node store with registered read. Indices past the store read as zero.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cmd.index[AW-1:0]] <= cmd.node;
        end
        rd_q  <= mem[raddr[AW-1:0]];
        oor_q <= (32'(raddr) >= NODE_COUNT);
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_idx_next    = cur_idx_reg;
        cur_next        = cur_reg;
        cur_valid_next  = cur_valid_reg;
        nxt_idx_next    = nxt_idx_reg;
        byte_next       = byte_reg;
        bit_next        = bit_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = 1'b0;
        out_next        = out_reg;
        raddr           = cur_idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.kind == REQ_LOAD)
                    begin
                        if (cmd.index == cur_idx_reg)
                        begin
                            cur_valid_next = 1'b0;
                        end
                    end
                    else
                    begin
                        byte_next = cmd.data;
                        bit_next  = BIT_W'(BYTE - 1);
                        if (cur_valid_reg)
                        begin
                            raddr = cmd.data[BYTE-1] ? cur_reg.right : cur_reg.left;
                            nxt_idx_next = raddr;
                            state_next   = ST_CHILD;
                        end
                        else
                        begin
                            raddr      = cur_idx_reg;
                            state_next = ST_CUR;
                        end
                    end
                end
            end

            ST_CUR:
            begin
                cur_next       = rd_node;
                cur_valid_next = 1'b1;
                raddr = byte_reg[bit_reg] ? rd_node.right : rd_node.left;
                nxt_idx_next = raddr;
                state_next   = ST_CHILD;
            end

            ST_CHILD:
            begin
                if (rd_node.leaf)
                begin
                    if (cnt_reg < cfg.msg_len)
                    begin
                        cnt_next = cnt_inc;
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                        end
                        pend_valid_next        = 1'b1;
                        pend_next.symbol       = rd_node.sym;
                        pend_next.last_in_run  = 1'b0;
                        pend_next.message_done = (cnt_inc == cfg.msg_len);
                    end
                    cur_idx_next   = cfg.root;
                    cur_valid_next = 1'b0;
                    raddr          = cfg.root;
                    if (byte_end)
                    begin
                        state_next = pend_valid_next ? ST_FLUSH : ST_IDLE;
                    end
                    else
                    begin
                        bit_next   = bit_reg - BIT_W'(1);
                        state_next = ST_CUR;
                    end
                end
                else
                begin
                    cur_idx_next   = nxt_idx_reg;
                    cur_next       = rd_node;
                    cur_valid_next = 1'b1;
                    if (byte_end)
                    begin
                        state_next = pend_valid_reg ? ST_FLUSH : ST_IDLE;
                    end
                    else
                    begin
                        bit_next = bit_reg - BIT_W'(1);
                        raddr = byte_reg[bit_next] ? rd_node.right : rd_node.left;
                        nxt_idx_next = raddr;
                    end
                end
            end

            ST_FLUSH:
            begin
                out_valid_next        = 1'b1;
                out_next              = pend_reg;
                out_next.last_in_run  = 1'b1;
                pend_valid_next       = 1'b0;
                state_next            = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // The user must write registers only while the walker is idle.
        if (cfg.root_wr)
        begin
            cur_idx_next   = cfg.root_wdata;
            cur_valid_next = 1'b0;
        end
        if (cfg.len_wr)
        begin
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_idx_reg    <= '0;
            cur_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_idx_reg    <= cur_idx_next;
            cur_valid_reg  <= cur_valid_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        nxt_idx_reg <= nxt_idx_next;
        byte_reg    <= byte_next;
        bit_reg     <= bit_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
    end

endmodule

// ----- hw/rtl/huffman_tree_walk_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder: Huffman decoder walking a code tree in a store
// Load items write tree nodes; byte items are decoded MSB first into symbols.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                     Payload
// -------   ---------  ----------------------------  ------------------------
// request   in         start high while busy low     req_t (load or byte)
// result    out        result_valid, one cycle only  rsp_t (one symbol)
// config    in         APB write: psel/penable/pwrite root_node, message_length
//
// A byte item leaves the queue as its first node-store read is issued, then
// walks its bits in order, since each step needs the node read in the step
// before. Each leaf reached adds a step that fetches the root node again, and
// a byte that emits symbols ends with a step that puts out its final result.
// A load item is written to the node store as it leaves the queue.
// The two-entry queue lets the next items be taken while a byte is decoded;
// busy rises only when the queue is full. Reset clears the control state and
// both registers; the node store holds nothing usable until loaded.
// Results cannot be held off: each symbol shows on result for one cycle.
//
module huffman_tree_walk_decoder
    import htw_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  req_t                  request,
    output logic                  result_valid,
    output rsp_t                  result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cmd_t             cmd;
    logic             cmd_valid;
    logic             cmd_pop;
    cfg_t             cfg;
    logic [IDX_W-1:0] root_reg;
    logic [LEN_W-1:0] len_reg;
    logic             apb_wr;
    logic             reg_sel;

    // Register index is the word address; the byte lanes are ignored.
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign apb_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        if (reg_sel == REG_MESSAGE_LENGTH)
        begin
            prdata = APB_DATA_W'(len_reg);
        end
        else
        begin
            prdata = APB_DATA_W'(root_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= '0;
            len_reg  <= '0;
        end
        else if (apb_wr)
        begin
            if (reg_sel == REG_ROOT_NODE)
            begin
                root_reg <= pwdata[IDX_W-1:0];
            end
            else
            begin
                len_reg <= pwdata[LEN_W-1:0];
            end
        end
    end

    // The walker sees write events at the same edge the registers change,
    // so it can move to the new root and clear its symbol count.
    always_comb
    begin
        cfg.root       = root_reg;
        cfg.msg_len    = len_reg;
        cfg.root_wr    = apb_wr && (reg_sel == REG_ROOT_NODE);
        cfg.root_wdata = pwdata[IDX_W-1:0];
        cfg.len_wr     = apb_wr && (reg_sel == REG_MESSAGE_LENGTH);
    end

    htw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    htw_back #(
        .NODE_COUNT (NODE_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cmd_valid    (cmd_valid),
        .cmd_pop      (cmd_pop),
        .cfg          (cfg),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ----- verif/huffman_symbol_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_symbol_checker: decoded-symbol checker for the tree-walk decoder
// Watches the request, result and register channels, keeps its own copy of
// the code tree and walk state, and compares every symbol with its forecast.
// ----------------------------------------------------------------------------
module huffman_symbol_checker
    import htw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  req_t                  request,
    input  logic                  result_valid,
    input  rsp_t                  result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    mismatches,
    output int                    symbols_pending
);

    node_t            tree_copy [NODE_COUNT_DEF];
    logic [IDX_W-1:0] root_sel;
    logic [IDX_W-1:0] walk_at;
    logic [LEN_W-1:0] length_limit;
    logic [LEN_W-1:0] emitted_count;
    rsp_t             awaited_symbols [$];

    // Walks one stream byte through the tree copy and queues the symbols it
    // completes, marking the last one of the byte.
    task automatic walk_byte(input logic [BYTE-1:0] stream);
        node_t            here;
        node_t            reached;
        logic [IDX_W-1:0] target;
        rsp_t             found [BYTE];
        int               count;
        int               b;
        int               k;

        count = 0;
        for (b = BYTE - 1; b >= 0; b--)
        begin
            here    = tree_copy[walk_at];
            target  = stream[b] ? here.right : here.left;
            reached = tree_copy[target];
            if (reached.leaf)
            begin
                if (emitted_count < length_limit)
                begin
                    emitted_count               = emitted_count + 1'b1;
                    found[count].symbol         = reached.sym;
                    found[count].last_in_run    = 1'b0;
                    found[count].message_done   = (emitted_count == length_limit);
                    count++;
                end
                walk_at = root_sel;
            end
            else
            begin
                walk_at = target;
            end
        end
        for (k = 0; k < count; k++)
        begin
            if (k == count - 1)
            begin
                found[k].last_in_run = 1'b1;
            end
            awaited_symbols.insert(awaited_symbols.size(), found[k]);
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t want;

        if (!rst_n)
        begin
            root_sel      = '0;
            walk_at       = '0;
            length_limit  = '0;
            emitted_count = '0;
            mismatches    = 0;
            awaited_symbols.delete();
        end
        else
        begin
            if (result_valid)
            begin
                if (awaited_symbols.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected symbol: expected none,", $time,
                             " got sym %02h last %b done %b",
                             result.symbol, result.last_in_run, result.message_done);
                end
                else
                begin
                    want = awaited_symbols[0];
                    awaited_symbols.delete(0);
                    if (result.symbol !== want.symbol ||
                        result.last_in_run !== want.last_in_run ||
                        result.message_done !== want.message_done)
                    begin
                        mismatches++;
                        $display("%0t: symbol mismatch: expected sym %02h last %b done %b,",
                                 $time, want.symbol, want.last_in_run, want.message_done,
                                 " got sym %02h last %b done %b",
                                 result.symbol, result.last_in_run, result.message_done);
                    end
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                if (paddr[APB_ADDR_W-1:2] == REG_ROOT_NODE)
                begin
                    root_sel = pwdata[IDX_W-1:0];
                    walk_at  = root_sel;
                end
                else if (paddr[APB_ADDR_W-1:2] == REG_MESSAGE_LENGTH)
                begin
                    length_limit  = pwdata[LEN_W-1:0];
                    emitted_count = '0;
                end
            end

            if (start && !busy)
            begin
                if (request.req_type == REQ_LOAD)
                begin
                    tree_copy[request.node_index] = {request.left_child, request.right_child,
                                                     request.is_leaf, request.leaf_symbol};
                end
                else
                begin
                    walk_byte(request.data_byte);
                end
            end
        end
        symbols_pending <= awaited_symbols.size();
    end

endmodule

// ----- verif/huffman_tree_walk_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_tb: top of the tree-walk decoder testbench
// Loads code trees, streams bytes through them under several register
// settings and lets the symbol checker judge every decoded symbol.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder_tb;
    import htw_pkg::*;

    // Settle time after the last expected symbol. Up to two items can wait in
    // the queue behind the one being decoded, and a byte's walk covers its issue,
    // its eight bits, a root refetch per leaf and its final result.
    localparam int SETTLE_CYCLES = 64;
    // Cycles without any accepted item, symbol or register write that count
    // as a hang. Far above the longest quiet stretch of a correct run.
    localparam int QUIET_LIMIT   = 2000;
    localparam int ITEM_TARGET   = 420;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  start   = 1'b0;
    logic                  busy;
    req_t                  request = '0;
    logic                  result_valid;
    rsp_t                  result;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches;
    int symbols_pending;
    int items_sent  = 0;
    int quiet_count = 0;

    // Which store entries hold a node, and which belong to the tree in use.
    // Stray loads point children at written entries and trees load in full, so a walk
    // that starts on a written node never reaches an unwritten one.
    bit written [NODE_COUNT_DEF];
    bit in_tree [NODE_COUNT_DEF];

    always #5 clk = ~clk;

    huffman_tree_walk_decoder uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    huffman_symbol_checker u_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .request         (request),
        .result_valid    (result_valid),
        .result          (result),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .mismatches      (mismatches),
        .symbols_pending (symbols_pending)
    );

    // Hang detection: any accepted item, symbol or register write restarts
    // the count.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid
            || (psel && penable && pwrite && pready))
        begin
            quiet_count <= 0;
        end
        else if (quiet_count >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            quiet_count <= quiet_count + 1;
        end
    end

    // Offers one item and returns at the edge where it is taken. Start stays
    // high afterwards so that back-to-back items keep it high. The sender
    // leaves gaps about a quarter of the time, except for one long stretch
    // in the middle of the run where items come as fast as the block allows.
    task automatic drive_item(input req_t item);
        if (!(items_sent >= 200 && items_sent < 290) && $urandom_range(99) < 24)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 24)
            begin
                @(posedge clk);
            end
        end
        start   <= 1'b1;
        request <= item;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // A load item. The byte field is unused by a load and carries noise.
    task automatic load_node(input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] left,
                             input logic [IDX_W-1:0] right, input logic leaf,
                             input logic [SYM_W-1:0] sym);
        req_t item;

        item.req_type    = REQ_LOAD;
        item.node_index  = idx;
        item.left_child  = left;
        item.right_child = right;
        item.is_leaf     = leaf;
        item.leaf_symbol = sym;
        item.data_byte   = BYTE'($urandom_range(255));
        written[idx]     = 1'b1;
        drive_item(item);
    endtask

    // A decode item. Every field but the kind and the byte is noise the block must ignore.
    task automatic send_byte(input logic [BYTE-1:0] stream);
        logic [63:0] noise;
        req_t        item;

        noise          = {$urandom(), $urandom()};
        item           = noise[$bits(req_t)-1:0];
        item.req_type  = REQ_DECODE;
        item.data_byte = stream;
        drive_item(item);
    endtask

    // A random load outside the tree in use. Its children point at written
    // entries, or at itself, so later walks stay on written nodes.
    task automatic stray_load();
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;

        do
        begin
            idx = IDX_W'($urandom_range(NODE_COUNT_DEF - 1));
        end
        while (in_tree[idx]);
        left  = IDX_W'($urandom_range(NODE_COUNT_DEF - 1));
        right = IDX_W'($urandom_range(NODE_COUNT_DEF - 1));
        if (!written[left])
        begin
            left = idx;
        end
        if (!written[right])
        begin
            right = idx;
        end
        load_node(idx, left, right, 1'($urandom_range(1)), SYM_W'($urandom_range(255)));
    endtask

    // One register write: a setup phase, an access phase that waits for pready,
    // then the port idle so that a following write starts cleanly.
    task automatic write_reg(input logic sel, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Register writes carry random bits above the field, which the block
    // must drop.
    task automatic set_root(input logic [IDX_W-1:0] root);
        logic [APB_DATA_W-1:0] word;

        word            = $urandom();
        word[IDX_W-1:0] = root;
        write_reg(REG_ROOT_NODE, word);
    endtask

    task automatic set_length(input logic [LEN_W-1:0] len);
        logic [APB_DATA_W-1:0] word;

        word            = $urandom();
        word[LEN_W-1:0] = len;
        write_reg(REG_MESSAGE_LENGTH, word);
    endtask

    // Stops offering items and waits until every forecast symbol has come
    // out, then lets the queue drain bytes that decode to nothing.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (symbols_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Grows a random full binary tree with the given number of leaves on
    // distinct random store entries, points the root register at it and
    // loads it. Leaf children point back into the tree, which only matters
    // when the root itself is a leaf.
    task automatic build_tree(input int leaves);
        int               slot     [64];
        int               lc       [64];
        int               rc       [64];
        bit               internal [64];
        int               n;
        int               j;
        int               k;
        logic [IDX_W-1:0] pick;

        in_tree = '{default: 1'b0};
        do
        begin
            pick = IDX_W'($urandom_range(NODE_COUNT_DEF - 1));
        end
        while (in_tree[pick]);
        in_tree[pick] = 1'b1;
        slot[0]       = int'(pick);
        internal[0]   = 1'b0;
        n             = 1;
        while (n < 2 * leaves - 1)
        begin
            do
            begin
                j = int'($urandom_range(n - 1));
            end
            while (internal[j]);
            internal[j] = 1'b1;
            lc[j]       = n;
            rc[j]       = n + 1;
            for (k = 0; k < 2; k++)
            begin
                do
                begin
                    pick = IDX_W'($urandom_range(NODE_COUNT_DEF - 1));
                end
                while (in_tree[pick]);
                in_tree[pick]   = 1'b1;
                slot[n + k]     = int'(pick);
                internal[n + k] = 1'b0;
            end
            n += 2;
        end

        set_root(IDX_W'(slot[0]));
        for (k = 0; k < n; k++)
        begin
            if (internal[k])
            begin
                load_node(IDX_W'(slot[k]), IDX_W'(slot[lc[k]]), IDX_W'(slot[rc[k]]),
                          1'b0, SYM_W'($urandom_range(255)));
            end
            else
            begin
                load_node(IDX_W'(slot[k]), IDX_W'(slot[$urandom_range(n - 1)]),
                          IDX_W'(slot[$urandom_range(n - 1)]),
                          1'b1, SYM_W'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        int  leaves;
        int  byte_count;
        int  roll;
        int  b;
        bit  fresh_tree;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A root that is itself a leaf and points at itself: every bit
        // completes a symbol, so each byte yields the full eight results.
        set_root(9'd511);
        set_length(LEN_MAX);
        load_node(9'd511, 9'd511, 9'd511, 1'b1, 8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);

        // A short message: the third symbol completes it, the rest of the
        // byte and the whole next byte are dropped.
        settle();
        set_length(31'd3);
        send_byte(8'h5A);
        send_byte(8'h00);

        // A small tree rooted at entry 0. A 0 bit gives symbol 00 at once;
        // a 1 bit enters node 2, which loops on 0 bits and leaves on a 1 bit
        // to the leaf at 511. A zero length first drops every symbol.
        settle();
        set_root(9'd0);
        set_length(31'd0);
        load_node(9'd0, 9'd1, 9'd2, 1'b0, 8'h3C);
        load_node(9'd1, 9'd0, 9'd511, 1'b1, 8'h00);
        load_node(9'd2, 9'd2, 9'd511, 1'b0, 8'hC3);
        send_byte(8'hC3);

        // Full length again. The second byte completes no symbol, the third
        // finishes a code begun in the byte before, and the last one leaves
        // the walk halfway down the tree.
        settle();
        set_length(LEN_MAX);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h01);

        // Rewriting the root must pull the walk back to the top of the tree.
        settle();
        set_root(9'd0);
        send_byte(8'h7F);

        // Random phases: each one settles, may change the message length,
        // usually loads a fresh tree, then streams bytes with the odd stray
        // load mixed in. The settle at the start of each phase also makes the
        // sender wait for every outstanding symbol.
        fresh_tree = 1'b1;
        while (items_sent < ITEM_TARGET)
        begin
            settle();
            if ($urandom_range(3) != 0)
            begin
                roll = int'($urandom_range(99));
                if (roll < 5)
                begin
                    set_length(31'd0);
                end
                else if (roll < 25)
                begin
                    set_length(LEN_MAX);
                end
                else if (roll < 80)
                begin
                    set_length(LEN_W'($urandom_range(40, 1)));
                end
                else
                begin
                    set_length(LEN_W'($urandom()));
                end
            end
            if (fresh_tree || $urandom_range(3) != 0)
            begin
                roll = int'($urandom_range(99));
                if (roll < 8)
                begin
                    leaves = 1;
                end
                else if (roll < 85)
                begin
                    leaves = int'($urandom_range(10, 2));
                end
                else
                begin
                    leaves = int'($urandom_range(32, 11));
                end
                build_tree(leaves);
                fresh_tree = 1'b0;
            end
            byte_count = int'($urandom_range(24, 6));
            for (b = 0; b < byte_count; b++)
            begin
                if ($urandom_range(7) == 0)
                begin
                    stray_load();
                end
                send_byte(BYTE'($urandom_range(255)));
            end
        end

        settle();
        if (mismatches == 0 && symbols_pending == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
